/* rtl/roberts_cross_edge_magnitude_core_defines.svh */
// ----------------------------------------------------------------------------
// roberts cross core assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef ROBERTS_CROSS_EDGE_MAGNITUDE_CORE_DEFINES_SVH
`define ROBERTS_CROSS_EDGE_MAGNITUDE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while in reset
`define RCE_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rce assertion failed");

// next-cycle implication, disabled while in reset
`define RCE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rce assertion failed");

`else

`define RCE_ASSERT_IMP(name, clk, rstn, ante, cons)
`define RCE_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

/* rtl/rce_pkg.sv */
// ----------------------------------------------------------------------------
// rce_pkg
// shared widths, codes, types and the roberts magnitude function
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rce_pkg;

    localparam int PIXEL_W       = 8;
    localparam int ROW_W         = 12;
    localparam int COL_W         = 10;
    localparam int FW_W          = 11;
    localparam int FH_W          = 13;
    localparam int MAXV_W        = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;
    localparam int RES_N         = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam logic [FW_W-1:0]   FW_RESET   = 11'd1024;
    localparam logic [FH_W-1:0]   FH_RESET   = 13'd1024;
    localparam logic [MAXV_W-1:0] MAXV_RESET = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE    = 2'd2;

    // result slots of one pixel, in delivery order
    localparam logic [1:0] RES_UPPER_DIAG = 2'd0;  // (r-1, c-1), full window
    localparam logic [1:0] RES_UPPER_EDGE = 2'd1;  // (r-1, c), right edge
    localparam logic [1:0] RES_LOWER_DIAG = 2'd2;  // (r, c-1), bottom edge
    localparam logic [1:0] RES_LOWER_EDGE = 2'd3;  // (r, c), bottom right corner

    // one classified pixel with its 2x2 neighbourhood
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [PIXEL_W-1:0] prev_pixel;
        logic [PIXEL_W-1:0] upper_left;
        logic [PIXEL_W-1:0] upper;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [RES_N-1:0]   mask;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // |b-c| + |a-d| saturated at ceiling; differences never exceed 255
    function automatic logic [PIXEL_W-1:0] roberts_mag(
        input logic [PIXEL_W-1:0] a,
        input logic [PIXEL_W-1:0] b,
        input logic [PIXEL_W-1:0] c,
        input logic [PIXEL_W-1:0] d,
        input logic [MAXV_W-1:0]  ceiling
    );
        logic [PIXEL_W:0] dx;
        logic [PIXEL_W:0] dy;
        logic [PIXEL_W:0] ax;
        logic [PIXEL_W:0] ay;
        logic [PIXEL_W:0] sum;
        dx  = {1'b0, b} - {1'b0, c};
        dy  = {1'b0, a} - {1'b0, d};
        ax  = dx[PIXEL_W] ? ({(PIXEL_W+1){1'b0}} - dx) : dx;
        ay  = dy[PIXEL_W] ? ({(PIXEL_W+1){1'b0}} - dy) : dy;
        sum = {1'b0, ax[PIXEL_W-1:0]} + {1'b0, ay[PIXEL_W-1:0]};
        return (sum > {1'b0, ceiling}) ? ceiling : sum[PIXEL_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/rce_ram.sv */
// ----------------------------------------------------------------------------
// rce_ram
// simple dual port ram, one write and one registered read, read-first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // same-address read returns the old contents
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/rce_front.sv */
// ----------------------------------------------------------------------------
// rce_front
// pixel intake, raster counters, line buffer and result classification
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rce_front #(
    parameter int MAX_WIDTH = rce_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [rce_pkg::PIXEL_W-1:0]   s_pixel,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          restart,
    input  wire logic [rce_pkg::FW_W-1:0]      frame_width,
    input  wire logic [rce_pkg::FH_W-1:0]      frame_height,
    input  wire logic                          q_full,
    output logic                               push,
    output rce_pkg::bundle_t                   bundle,
    output logic                               busy
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam logic [CW-1:0] W_LAST_MAX = CW'(MAX_WIDTH - 1);
    localparam logic [rce_pkg::ROW_W-1:0] H_LAST_MAX =
        rce_pkg::ROW_W'(rce_pkg::HEIGHT_LIMIT - 1);

    logic [CW-1:0]                  col_reg, col_next;
    logic [rce_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [rce_pkg::PIXEL_W-1:0]    pp_reg, pp_next;
    logic                           s1_valid_reg;
    logic [rce_pkg::PIXEL_W-1:0]    s1_pix_reg;
    logic [rce_pkg::PIXEL_W-1:0]    s1_pp_reg;
    logic [rce_pkg::ROW_W-1:0]      s1_row_reg;
    logic [rce_pkg::COL_W-1:0]      s1_col_reg;
    logic [rce_pkg::RES_N-1:0]      s1_mask_reg;
    logic [rce_pkg::PIXEL_W-1:0]    ul_reg;
    logic [rce_pkg::PIXEL_W-1:0]    upper;

    logic [CW-1:0]                  w_last;
    logic [rce_pkg::ROW_W-1:0]      h_last;
    logic [31:0]                    fw_ext;
    logic [31:0]                    fw_m1;
    logic [rce_pkg::FH_W-1:0]       fh_m1;
    logic [31:0]                    col_ext;
    logic                           accept;
    logic                           last_col;
    logic                           last_row;
    logic                           s1_adv;
    logic [rce_pkg::RES_N-1:0]      mask;

    // effective frame size, out-of-range values clamped
    always_comb begin
        fw_ext = 32'(frame_width);
        fw_m1  = fw_ext - 32'd1;
        fh_m1  = frame_height - 13'd1;
        if (frame_width == '0) begin
            w_last = '0;
        end else if (fw_ext > 32'(MAX_WIDTH)) begin
            w_last = W_LAST_MAX;
        end else begin
            w_last = fw_m1[CW-1:0];
        end
        if (frame_height == '0) begin
            h_last = '0;
        end else if (32'(frame_height) > 32'(rce_pkg::HEIGHT_LIMIT)) begin
            h_last = H_LAST_MAX;
        end else begin
            h_last = fh_m1[rce_pkg::ROW_W-1:0];
        end
    end

    assign col_ext  = 32'(col_reg);
    assign last_col = (col_reg == w_last);
    assign last_row = (row_reg == h_last);

    always_comb begin
        mask = '0;
        mask[rce_pkg::RES_UPPER_DIAG] = (row_reg != '0) && (col_reg != '0);
        mask[rce_pkg::RES_UPPER_EDGE] = (row_reg != '0) && last_col;
        mask[rce_pkg::RES_LOWER_DIAG] = last_row && (col_reg != '0);
        mask[rce_pkg::RES_LOWER_EDGE] = last_row && last_col;
    end

    // pixels without results are dropped here
    assign s1_adv  = s1_valid_reg && ((s1_mask_reg == '0) || !q_full);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;
    assign push    = s1_valid_reg && (s1_mask_reg != '0) && !q_full;
    assign busy    = s1_valid_reg;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        pp_next  = pp_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 12'd1;
                pp_next  = '0;
            end else begin
                col_next = col_reg + CW'(1);
                pp_next  = s_pixel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            pp_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (restart) begin
                col_reg <= '0;
                row_reg <= '0;
                pp_reg  <= '0;
            end else begin
                col_reg <= col_next;
                row_reg <= row_next;
                pp_reg  <= pp_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= s_pixel;
            s1_pp_reg   <= pp_reg;
            s1_row_reg  <= row_reg;
            s1_col_reg  <= col_ext[rce_pkg::COL_W-1:0];
            s1_mask_reg <= mask;
        end
        // upper row value of this column becomes the upper-left of the next
        if (s1_adv) begin
            ul_reg <= upper;
        end
    end

    // line buffer: read the upper row and overwrite it with this pixel
    rce_ram #(
        .WIDTH (rce_pkg::PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (s_pixel),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (upper)
    );

    always_comb begin
        bundle.pixel      = s1_pix_reg;
        bundle.prev_pixel = s1_pp_reg;
        bundle.upper_left = ul_reg;
        bundle.upper      = upper;
        bundle.row        = s1_row_reg;
        bundle.col        = s1_col_reg;
        bundle.mask       = s1_mask_reg;
    end

endmodule

`default_nettype wire

/* rtl/rce_queue.sv */
// ----------------------------------------------------------------------------
// rce_queue
// short register fifo of classified pixels between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rce_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire rce_pkg::bundle_t   push_data,
    input  wire logic               pop,
    output rce_pkg::bundle_t        head,
    output rce_pkg::queue_status_t  stat
);

    localparam int PW = $clog2(rce_pkg::QUEUE_DEPTH);

    rce_pkg::bundle_t entry_reg [rce_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (PW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (PW+1)'(rce_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

/* rtl/rce_back.sv */
// ----------------------------------------------------------------------------
// rce_back
// unpacks classified pixels into results, one magnitude per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rce_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire rce_pkg::bundle_t             head,
    input  wire logic                         q_empty,
    output logic                              pop,
    input  wire logic [rce_pkg::MAXV_W-1:0]   max_value,
    output logic [rce_pkg::PIXEL_W-1:0]       magnitude,
    output logic [rce_pkg::ROW_W-1:0]         out_row,
    output logic [rce_pkg::COL_W-1:0]         out_col,
    output logic                              frame_end,
    output logic                              m_valid,
    input  wire logic                         m_ready
);

    rce_pkg::bundle_t               cur_reg;
    logic [rce_pkg::RES_N-1:0]      mask_reg, mask_next;
    logic                           m_valid_reg;
    logic [rce_pkg::PIXEL_W-1:0]    mag_reg;
    logic [rce_pkg::ROW_W-1:0]      row_reg;
    logic [rce_pkg::COL_W-1:0]      col_reg;
    logic                           end_reg;

    logic                           out_free;
    logic                           have;
    logic [1:0]                     sel;
    logic [rce_pkg::PIXEL_W-1:0]    wa, wb, wc, wd;
    logic [rce_pkg::ROW_W-1:0]      res_row;
    logic [rce_pkg::COL_W-1:0]      res_col;
    logic                           res_end;
    logic [rce_pkg::RES_N-1:0]      mask_after;

    assign out_free = !m_valid_reg || m_ready;
    assign have     = (mask_reg != '0);

    // lowest pending slot first
    always_comb begin
        if (mask_reg[rce_pkg::RES_UPPER_DIAG]) begin
            sel = rce_pkg::RES_UPPER_DIAG;
        end else if (mask_reg[rce_pkg::RES_UPPER_EDGE]) begin
            sel = rce_pkg::RES_UPPER_EDGE;
        end else if (mask_reg[rce_pkg::RES_LOWER_DIAG]) begin
            sel = rce_pkg::RES_LOWER_DIAG;
        end else begin
            sel = rce_pkg::RES_LOWER_EDGE;
        end
    end

    always_comb begin
        wa      = '0;
        wb      = '0;
        wc      = '0;
        wd      = '0;
        res_row = cur_reg.row;
        res_col = cur_reg.col;
        res_end = 1'b0;
        case (sel)
            rce_pkg::RES_UPPER_DIAG: begin
                wa      = cur_reg.upper_left;
                wb      = cur_reg.upper;
                wc      = cur_reg.prev_pixel;
                wd      = cur_reg.pixel;
                res_row = cur_reg.row - 12'd1;
                res_col = cur_reg.col - 10'd1;
            end
            rce_pkg::RES_UPPER_EDGE: begin
                wa      = cur_reg.upper;
                wc      = cur_reg.pixel;
                res_row = cur_reg.row - 12'd1;
            end
            rce_pkg::RES_LOWER_DIAG: begin
                wa      = cur_reg.prev_pixel;
                wb      = cur_reg.pixel;
                res_col = cur_reg.col - 10'd1;
            end
            default: begin
                wa      = cur_reg.pixel;
                res_end = 1'b1;
            end
        endcase
    end

    always_comb begin
        mask_after = mask_reg;
        if (out_free && have) begin
            mask_after[sel] = 1'b0;
        end
    end

    assign pop = !q_empty && (mask_after == '0);

    always_comb begin
        mask_next = mask_after;
        if (pop) begin
            mask_next = head.mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg <= mask_next;
            if (out_free) begin
                m_valid_reg <= have;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head;
        end
        if (out_free && have) begin
            mag_reg <= rce_pkg::roberts_mag(wa, wb, wc, wd, max_value);
            row_reg <= res_row;
            col_reg <= res_col;
            end_reg <= res_end;
        end
    end

    assign m_valid   = m_valid_reg;
    assign magnitude = mag_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign frame_end = end_reg;

endmodule

`default_nettype wire

/* rtl/roberts_cross_edge_magnitude_core.sv */
// ----------------------------------------------------------------------------
// roberts_cross_edge_magnitude_core
// path: a taken pixel passes the front stage, the queue and the back window register
// throughput: one pixel per cycle, one result per cycle while m_tready holds, set by
//   the single output register; the last column and last row burst up to 4 results
//   per pixel, absorbed by the 4-entry queue, the front stalling when it fills
// reset: aresetn synchronous, clears counters, queue and valids, loads
//   frame_width 1024, frame_height 1024, max_value 255; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "roberts_cross_edge_magnitude_core_defines.svh"

module roberts_cross_edge_magnitude_core #(
    parameter int MAX_WIDTH = rce_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // pixel stream in
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] pixel
    // result stream out
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [31:0]                            m_tdata,   // [7:0] magnitude,
                                                              // [19:8] out_row,
                                                              // [29:20] out_col,
                                                              // [31:30] zero
    output logic                                   m_tlast,   // frame_end
    // register write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [rce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rce_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // configuration registers
    logic [rce_pkg::FW_W-1:0]   frame_width_reg;
    logic [rce_pkg::FH_W-1:0]   frame_height_reg;
    logic [rce_pkg::MAXV_W-1:0] max_value_reg;
    logic                       restart;

    // front to queue to back
    rce_pkg::bundle_t           fr_bundle;
    rce_pkg::bundle_t           q_head;
    rce_pkg::queue_status_t     q_stat;
    logic                       q_push;
    logic                       q_pop;
    logic                       fr_busy;

    // result fields
    logic [rce_pkg::PIXEL_W-1:0] res_mag;
    logic [rce_pkg::ROW_W-1:0]   res_row;
    logic [rce_pkg::COL_W-1:0]   res_col;
    logic                        res_end;

    // any write to a known register restarts the frame
    always_comb begin
        case (cfg_index)
            rce_pkg::CFG_FRAME_WIDTH,
            rce_pkg::CFG_FRAME_HEIGHT,
            rce_pkg::CFG_MAX_VALUE:  restart = cfg_wr_en;
            default:                 restart = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= rce_pkg::FW_RESET;
            frame_height_reg <= rce_pkg::FH_RESET;
            max_value_reg    <= rce_pkg::MAXV_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rce_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[rce_pkg::FW_W-1:0];
                rce_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                rce_pkg::CFG_MAX_VALUE:    max_value_reg    <= cfg_wdata[rce_pkg::MAXV_W-1:0];
                default: ;
            endcase
        end
    end

    // front: raster position, line buffer, which results a pixel releases
    rce_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_pixel      (s_tdata),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .restart      (restart),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_full       (q_stat.full),
        .push         (q_push),
        .bundle       (fr_bundle),
        .busy         (fr_busy)
    );

    // queue decouples the pixel side from bursts on the result side
    rce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (fr_bundle),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // back: one magnitude per beat from the queued windows
    rce_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .q_empty   (q_stat.empty),
        .pop       (q_pop),
        .max_value (max_value_reg),
        .magnitude (res_mag),
        .out_row   (res_row),
        .out_col   (res_col),
        .frame_end (res_end),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready)
    );

    assign m_tdata = {2'b00, res_col, res_row, res_mag};
    assign m_tlast = res_end;

    // front never writes into a full queue, back never reads an empty one
    `RCE_ASSERT_IMP(a_push_not_full, aclk, aresetn, q_push, !q_stat.full)
    `RCE_ASSERT_IMP(a_pop_not_empty, aclk, aresetn, q_pop, !q_stat.empty)
    // a taken pixel beat always lands in the front stage
    `RCE_ASSERT_NEXT(a_accept_fills_front, aclk, aresetn, s_tvalid && s_tready, fr_busy)

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: roberts cross edge magnitude core
// drives a raster pixel stream under several frame geometries and ceilings,
// predicts every result beat with its own line buffer model and compares
// magnitude, coordinates and frame end beat by beat
// ----------------------------------------------------------------------------

module tb;

    // index outside the register map, written to check that it is ignored
    localparam logic [rce_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int SETTLE_CYCLES   = 8;     // pipeline runs through front stage, queue and back, leave margin
    localparam int HOLD_CYCLES     = 300;   // long output stall to fill the queue
    localparam int WATCHDOG_LIMIT  = 3000;  // well above the longest quiet stretch
    localparam int RANDOM_ITEMS    = 255;
    localparam int RESET_ROW_ITEMS = 16;
    localparam int COLUMN_ITEMS    = 32;
    localparam int ROW_ITEMS       = 48;

    typedef logic [rce_pkg::CFG_DATA_W-1:0] cfg_word_t;

    // one result beat split into its fields
    typedef struct packed {
        logic [7:0]  mag;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } edge_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: line buffer predictor plus queue of expected result beats
    // ------------------------------------------------------------------------
    class roberts_scoreboard;
        bit [7:0]     line_buf [rce_pkg::DEF_MAX_WIDTH];
        bit [7:0]     left_px;
        int unsigned  row_idx;
        int unsigned  col_idx;
        bit [10:0]    width_reg;
        bit [12:0]    height_reg;
        bit [7:0]     ceil_reg;
        edge_result_t pending_mags [$];
        int unsigned  errors;
        int unsigned  pixels;
        int unsigned  results;
        int unsigned  writes;

        function new();
            width_reg  = rce_pkg::FW_RESET;
            height_reg = rce_pkg::FH_RESET;
            ceil_reg   = rce_pkg::MAXV_RESET;
            restart();
        endfunction

        function void restart();
            left_px = 8'd0;
            row_idx = 0;
            col_idx = 0;
        endfunction

        // any valid register write also starts a fresh frame
        function void load_reg(logic [rce_pkg::CFG_IDX_W-1:0] idx, cfg_word_t val);
            bit hit;
            hit = 1'b1;
            case (idx)
                rce_pkg::CFG_FRAME_WIDTH:  width_reg  = val[10:0];
                rce_pkg::CFG_FRAME_HEIGHT: height_reg = val[12:0];
                rce_pkg::CFG_MAX_VALUE:    ceil_reg   = val[7:0];
                default:                   hit = 1'b0;
            endcase
            writes++;
            if (hit)
                restart();
        endfunction

        // |b-c| + |a-d|, capped at the programmed ceiling
        function bit [7:0] cross_magnitude(int a, int b, int c, int d);
            int gx;
            int gy;
            int sum;
            gx  = b - c;
            gy  = a - d;
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            sum = gx + gy;
            return (sum > ceil_reg) ? ceil_reg : sum[7:0];
        endfunction

        function void expect_mag(bit [7:0] mag, int unsigned row, int unsigned col, bit last);
            edge_result_t res;
            res.mag  = mag;
            res.row  = row[11:0];
            res.col  = col[9:0];
            res.last = last;
            pending_mags.push_back(res);
        endfunction

        // one accepted pixel beat: emit every window it completes
        function void take_pixel(bit [7:0] px);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            bit [7:0]    pp;
            bit          last_col;
            w  = (width_reg == 0) ? 1 :
                 (width_reg > rce_pkg::DEF_MAX_WIDTH) ? rce_pkg::DEF_MAX_WIDTH : width_reg;
            h  = (height_reg == 0) ? 1 :
                 (height_reg > rce_pkg::HEIGHT_LIMIT) ? rce_pkg::HEIGHT_LIMIT : height_reg;
            r  = row_idx;
            c  = col_idx;
            pp = left_px;
            if (r >= h || c >= w) begin
                r  = 0;
                c  = 0;
                pp = 8'd0;
            end
            last_col = (c == w - 1);

            // upper row first, then the bottom row of the frame
            if (r >= 1) begin
                if (c >= 1)
                    expect_mag(cross_magnitude(line_buf[c-1], line_buf[c], pp, px),
                               r - 1, c - 1, 1'b0);
                if (last_col)
                    expect_mag(cross_magnitude(line_buf[c], 0, px, 0), r - 1, c, 1'b0);
            end
            if (r == h - 1) begin
                if (c >= 1)
                    expect_mag(cross_magnitude(pp, px, 0, 0), r, c - 1, 1'b0);
                if (last_col)
                    expect_mag(cross_magnitude(px, 0, 0, 0), r, c, 1'b1);
            end

            // line buffer write trails by one column so the upper row survives
            if (c >= 1)
                line_buf[c-1] = pp;
            if (last_col)
                line_buf[c] = px;
            left_px = px;

            if (last_col) begin
                c       = 0;
                r       = (r + 1 >= h) ? 0 : r + 1;
                left_px = 8'd0;
            end else begin
                c++;
            end
            row_idx = r;
            col_idx = c;
            pixels++;
        endfunction

        function void mismatch(string field, int unsigned want, int unsigned got);
            errors++;
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(edge_result_t got);
            edge_result_t want;
            if (pending_mags.size() == 0) begin
                errors++;
                $error("result beat with nothing expected: row %0d col %0d mag %0d",
                       got.row, got.col, got.mag);
                return;
            end
            want = pending_mags.pop_front();
            results++;
            if (got.mag  != want.mag)  mismatch("magnitude", want.mag, got.mag);
            if (got.row  != want.row)  mismatch("out_row", want.row, got.row);
            if (got.col  != want.col)  mismatch("out_col", want.col, got.col);
            if (got.last != want.last) mismatch("frame_end", want.last, got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------------
    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [7:0]                        s_tdata   = 8'd0;   // [7:0] pixel
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [31:0]                       m_tdata;            // [7:0] magnitude, [19:8] out_row,
                                                           // [29:20] out_col, [31:30] zero
    logic                              m_tlast;            // frame_end
    logic                              cfg_wr_en = 1'b0;
    logic [rce_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    cfg_word_t                         cfg_wdata = '0;

    roberts_scoreboard sb;

    // idling percentages for each side, changed between stretches of the run
    int          send_idle_pct;
    int          recv_idle_pct;
    // the main sequence bumps this to ask the receiver for one long stall
    int          hold_requests = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    int unsigned random_items  = 0;
    logic [7:0]  last_px       = 8'd0;
    edge_result_t out_beat;

    roberts_cross_edge_magnitude_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // result side ready: random stalls, or one long hold when asked for
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  = 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_requests != hold_seen) begin
            // long hold: the queue fills and the pixel side has to back off
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            m_tready  = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: sample both channels at the rising edge, watchdog on progress
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.take_pixel(s_tdata);
            if (m_tvalid && m_tready) begin
                out_beat = '{m_tdata[7:0], m_tdata[19:8], m_tdata[29:20], m_tlast};
                sb.check_result(out_beat);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                         quiet_cycles, sb.pending_mags.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------------

    // 0: uniform, 1: black or white only, 2: slowly drifting grey
    function automatic logic [7:0] next_pixel(int unsigned style);
        case (style)
            0:       last_px = 8'($urandom_range(255));
            1:       last_px = $urandom_range(1) ? 8'hFF : 8'h00;
            default: last_px = last_px + 8'($urandom_range(16)) - 8'd8;
        endcase
        return last_px;
    endfunction

    // offer one pixel beat and hold it until taken; idle cycles carry junk data
    task automatic push_pixel(input logic [7:0] px);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom_range(255));
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = px;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // drain all expected results, then let trailing pixels leave the pipeline
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending_mags.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [rce_pkg::CFG_IDX_W-1:0] idx,
                             input cfg_word_t val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge aclk);
        sb.load_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_frame(input cfg_word_t w,
                             input cfg_word_t h,
                             input cfg_word_t ceiling);
        write_reg(rce_pkg::CFG_FRAME_WIDTH, w);
        write_reg(rce_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(rce_pkg::CFG_MAX_VALUE, ceiling);
    endtask

    // small random geometry, one to three frames, sometimes a trailing partial,
    // never running past the pixel budget of the current stretch
    task automatic random_phase(input int unsigned limit);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned style;
        logic [7:0]  ceiling;
        w = ($urandom_range(3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        case ($urandom_range(3))
            0:       ceiling = 8'($urandom_range(255));
            1:       ceiling = 8'($urandom_range(40));
            default: ceiling = 8'd255;
        endcase
        set_frame(cfg_word_t'(w), cfg_word_t'(h), cfg_word_t'(ceiling));
        n = $urandom_range(1, (w > 8) ? 2 : 3) * w * h;
        if ($urandom_range(2) == 0)
            n = n + $urandom_range(w * h - 1);
        if (n > limit - random_items)
            n = limit - random_items;
        style = $urandom_range(2);
        repeat (n) push_pixel(next_pixel(style));
        settle();
        random_items = random_items + n;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        // 3x3 mix of full swings, saturates at a ceiling of 255
        logic [7:0] swing [9];

        swing         = '{8'd255, 8'd255, 8'd0,
                          8'd0,   8'd0,   8'd255,
                          8'd255, 8'd0,   8'd255};
        sb            = new();
        send_idle_pct = 21;
        recv_idle_pct = 54;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset geometry: a stretch of row 0 of a tall frame, no result is due
        repeat (RESET_ROW_ITEMS) push_pixel(next_pixel(0));
        settle();

        // width written with junk above its 11 bits, only the low bits count
        set_frame(13'h1803, 13'd3, 13'd255);
        for (int i = 0; i < 4; i++)
            push_pixel(swing[i]);
        settle();
        // unmapped index must neither land anywhere nor restart the frame
        write_reg(CFG_SPARE, 13'h1FFF);
        for (int i = 4; i < 9; i++)
            push_pixel(swing[i]);
        settle();

        // zero ceiling: every magnitude clamps to 0
        set_frame(13'd2, 13'd2, 13'd0);
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd0);
        push_pixel(8'd255);
        settle();

        // zero width and height act as 1x1 frames, each pixel its own corner
        set_frame(13'd0, 13'd0, 13'd200);
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd201);
        settle();

        // single column
        set_frame(13'd1, 13'd3, 13'd100);
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd128);
        settle();

        while (random_items < RANDOM_ITEMS / 3)
            random_phase(RANDOM_ITEMS / 3);

        // sender now the slower side
        send_idle_pct = 54;
        recv_idle_pct = 21;

        // tallest frame, one column wide, top stretch of it
        set_frame(13'd1, cfg_word_t'(rce_pkg::HEIGHT_LIMIT), cfg_word_t'($urandom_range(255)));
        repeat (COLUMN_ITEMS) push_pixel(next_pixel(2));
        settle();

        // width beyond the line buffer falls back to its full size
        set_frame(13'd1500, 13'd1, 13'd255);
        repeat (ROW_ITEMS) push_pixel(next_pixel(0));
        settle();

        while (random_items < 2 * RANDOM_ITEMS / 3)
            random_phase(2 * RANDOM_ITEMS / 3);

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // widest single row, every pixel after the first gives a result,
        // opened by a long hold
        set_frame(cfg_word_t'(rce_pkg::DEF_MAX_WIDTH), 13'd1, 13'd255);
        hold_requests = hold_requests + 1;
        repeat (ROW_ITEMS) push_pixel(next_pixel(1));
        settle();

        // height beyond the limit falls back to 4096 rows
        set_frame(13'd1, 13'h1FFF, 13'd255);
        repeat (COLUMN_ITEMS) push_pixel(next_pixel(0));
        settle();

        hold_requests = hold_requests + 1;
        while (random_items < RANDOM_ITEMS)
            random_phase(RANDOM_ITEMS);

        $display("run covered %0d pixel beats, %0d result beats, %0d register writes",
                 sb.pixels, sb.results, sb.writes);
        $display("geometries from 1x1 up to clamped width and height, ceilings 0 to 255, %0d errors",
                 sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/rce_pkg.sv
rtl/rce_ram.sv
rtl/rce_front.sv
rtl/rce_queue.sv
rtl/rce_back.sv
rtl/roberts_cross_edge_magnitude_core.sv
verif/tb.sv
